// ----- hdl/blm_pkg.sv -----
`default_nettype none

package blm_pkg;

  // Field widths of the item and result transactions.
  localparam int BAND_W  = 5;
  localparam int LEVEL_W = 8;
  localparam int AGE_W   = 10;

  // Default number of bands held in the band memory.
  localparam int BANDS_DEFAULT = 32;

  // Width used to compare a band number against the band count.
  localparam int BAND_CMP_W = 9;

  // Bar and roof rules.
  localparam logic [LEVEL_W-1:0] SMALL_RISE = LEVEL_W'(4);
  localparam logic [AGE_W-1:0]   AGE_MAX    = {AGE_W{1'b1}};

  // Division by three as a multiplication by a scaled reciprocal.
  // Exact for every dividend below 2**RECIP3_SHIFT.
  localparam int RECIP3_SHIFT = 11;
  localparam int SUM_W        = LEVEL_W + 2;
  localparam logic [SUM_W-1:0] RECIP3 = SUM_W'(683);

  // Configuration registers.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 8;
  localparam logic [CFG_REG_W-1:0] HOLD_RESET = CFG_REG_W'(32);
  localparam logic [CFG_REG_W-1:0] DIV_RESET  = CFG_REG_W'(26);
  localparam logic REG_HOLD_TIME     = 1'b0;
  localparam logic REG_DECAY_DIVISOR = 1'b1;

  // Item transaction.
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [BAND_W-1:0]  band_out;
    logic [LEVEL_W-1:0] bar_height;
    logic [LEVEL_W-1:0] roof_height;
  } out_t;

  // One band memory entry.
  typedef struct packed {
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] roof;
    logic [AGE_W-1:0]   age;
  } entry_t;

  // Item sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/band_level_meter_peak_hold.sv -----
// Peak-hold level meter with a decaying roof, one spectrum band per transaction.
// Input channel (in_valid, in_stall, in_data): a band number and a level already
// mapped to bar height. Result channel (out_valid, out_stall, out_data): the
// band, the smoothed bar height and the roof height shown for this frame.
// Configuration is an APB-style port: hold_time at byte address 0 and
// decay_divisor at byte address 4; write it only while the block is idle.
// Per band the bar, roof and roof age live in one band memory with a registered
// read; each item is a read, an update and a write-back. A new item is accepted
// only after the previous one is written back, and its result is registered in
// the finish step. When the roof is falling, a bit-serial divider computes
// age / decay_divisor, one quotient bit per cycle, and the item waits in a
// divide step until the quotient is ready.
// The next item is accepted while the previous result waits in the output
// register; a stalled receiver holds that register and, once a second result is
// ready, holds the block in its finish step until the slot frees.
// Reset clears the output valid bit, the sequencer and the valid bits of the
// band memory, so every band starts with bar, roof and age at zero; the
// registers return to hold_time 32 and decay_divisor 26.
`default_nettype none

module band_level_meter_peak_hold #(
  parameter int BANDS = blm_pkg::BANDS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire blm_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output blm_pkg::out_t                         out_data,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [blm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [blm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [blm_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int AW   = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int LW   = blm_pkg::LEVEL_W;
  localparam int GW   = blm_pkg::AGE_W;
  localparam int SW   = blm_pkg::SUM_W;
  localparam int RW   = blm_pkg::CFG_REG_W;
  localparam int CMPW = blm_pkg::BAND_CMP_W;

  // Configuration registers.
  logic [RW-1:0] hold_r;
  logic [RW-1:0] decay_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= blm_pkg::HOLD_RESET;
      decay_r <= blm_pkg::DIV_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        blm_pkg::REG_HOLD_TIME:     hold_r  <= cfg_pwdata[RW-1:0];
        blm_pkg::REG_DECAY_DIVISOR: decay_r <= cfg_pwdata[RW-1:0];
        default:                    hold_r  <= hold_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      blm_pkg::REG_HOLD_TIME:     cfg_prdata = {{(blm_pkg::CFG_DATA_W-RW){1'b0}}, hold_r};
      blm_pkg::REG_DECAY_DIVISOR: cfg_prdata = {{(blm_pkg::CFG_DATA_W-RW){1'b0}}, decay_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // Sequencer state and item registers.
  blm_pkg::state_t state_r, state_nxt;
  logic            in_acc;
  logic [LW-1:0]   level_r;
  logic [blm_pkg::BAND_W-1:0] band_r;
  logic [AW-1:0]   addr_r;
  logic            oor_r;
  logic [CMPW-1:0] band_ext;
  logic [AW-1:0]   in_addr;

  assign in_stall = (state_r != blm_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign band_ext = {{(CMPW-blm_pkg::BAND_W){1'b0}}, in_data.band};
  assign in_addr  = band_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      band_r  <= in_data.band;
      level_r <= in_data.level;
      addr_r  <= in_addr;
      oor_r   <= (band_ext >= CMPW'(BANDS));
    end
  end

  // Band memory: read at acceptance, written back in the finish step.
  blm_pkg::entry_t rd_ent, wr_ent;
  logic            mem_wr;

  blm_band_mem #(
    .BANDS (BANDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_ent),
    .wr_en   (mem_wr),
    .wr_addr (addr_r),
    .wr_data (wr_ent)
  );

  // Bar and roof update on the entry just read.
  logic [SW-1:0]    sum3;
  logic [2*SW-1:0]  prod3;
  logic [LW-1:0]    avg3;
  logic [LW-1:0]    bar_new;
  logic [LW-1:0]    roof_new;
  logic [GW-1:0]    age_new;
  logic             need_div;

  always_comb begin
    sum3  = {1'b0, rd_ent.bar, 1'b0} + {2'b00, level_r};
    prod3 = {{SW{1'b0}}, sum3} * {{SW{1'b0}}, blm_pkg::RECIP3};
    avg3  = prod3[blm_pkg::RECIP3_SHIFT +: LW];

    if ({1'b0, level_r} > ({1'b0, rd_ent.bar} + {1'b0, blm_pkg::SMALL_RISE})) begin
      bar_new = avg3;
    end else if (level_r < rd_ent.bar) begin
      bar_new = rd_ent.bar - LW'(1);
    end else begin
      bar_new = level_r;
    end

    if (bar_new > rd_ent.roof) begin
      roof_new = bar_new;
      age_new  = GW'(1);
    end else begin
      roof_new = rd_ent.roof;
      age_new  = rd_ent.age;
    end

    need_div = (age_new != '0) && (age_new > {{(GW-RW){1'b0}}, hold_r});
  end

  logic [LW-1:0] bar_r;
  logic [LW-1:0] roof_r;
  logic [GW-1:0] age_r;
  logic          need_div_r;

  always_ff @(posedge clk) begin
    if (state_r == blm_pkg::ST_READ) begin
      bar_r      <= oor_r ? '0 : bar_new;
      roof_r     <= oor_r ? '0 : roof_new;
      age_r      <= oor_r ? '0 : age_new;
      need_div_r <= !oor_r && need_div;
    end
  end

  // Roof fall: age divided by the decay divisor, a zero divisor taken as one.
  logic          div_start;
  logic          div_busy;
  logic [GW-1:0] div_quo;
  logic [RW-1:0] div_dvs;

  assign div_dvs = (decay_r == '0) ? RW'(1) : decay_r;

  blm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (age_new),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Aging of the roof for the next frame.
  logic [GW-1:0] fall;
  logic [LW-1:0] roof_fin;
  logic [GW-1:0] age_fin;

  always_comb begin
    fall = need_div_r ? div_quo : '0;
    if (age_r == '0) begin
      roof_fin = roof_r;
      age_fin  = '0;
    end else if (fall > {{(GW-LW){1'b0}}, roof_r}) begin
      roof_fin = '0;
      age_fin  = '0;
    end else begin
      roof_fin = roof_r - fall[LW-1:0];
      age_fin  = (age_r == blm_pkg::AGE_MAX) ? age_r : age_r + GW'(1);
    end
    wr_ent.bar  = bar_r;
    wr_ent.roof = roof_fin;
    wr_ent.age  = age_fin;
  end

  // Output register; it loads when empty or when its transaction completes.
  logic          out_valid_r;
  blm_pkg::out_t out_data_r;
  logic          out_free;
  logic          out_load;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.band_out    <= band_r;
      out_data_r.bar_height  <= bar_r;
      out_data_r.roof_height <= roof_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: one item at a time, so a band is never read while its update is open.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    mem_wr    = 1'b0;
    unique case (state_r)
      blm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = blm_pkg::ST_READ;
        end
      end
      blm_pkg::ST_READ: begin
        if (!oor_r && need_div) begin
          div_start = 1'b1;
          state_nxt = blm_pkg::ST_DIV;
        end else begin
          state_nxt = blm_pkg::ST_FIN;
        end
      end
      blm_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = blm_pkg::ST_FIN;
        end
      end
      blm_pkg::ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          mem_wr    = !oor_r;
          state_nxt = blm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = blm_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/blm_band_mem.sv -----
`default_nettype none

module blm_band_mem #(
  parameter int BANDS = blm_pkg::BANDS_DEFAULT,
  parameter int AW    = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output blm_pkg::entry_t      rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire blm_pkg::entry_t wr_data
);

  blm_pkg::entry_t mem [BANDS];
  logic [BANDS-1:0] valid_r;
  blm_pkg::entry_t  rdata_r;
  logic             rvalid_r;

  // Synchronous write port; the valid bit marks an entry as written since reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ----- hdl/blm_div.sv -----
`default_nettype none

module blm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [blm_pkg::AGE_W-1:0]      dividend,
  input  wire logic [blm_pkg::CFG_REG_W-1:0]  divisor,
  output logic                                busy,
  output logic [blm_pkg::AGE_W-1:0]           quotient
);

  localparam int QW = blm_pkg::AGE_W;
  localparam int DW = blm_pkg::CFG_REG_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   shifted;
  logic          fits;

  // One restoring step per cycle: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted  = {rem_r, quo_r[QW-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    rem_nxt  = fits ? DW'(shifted - {1'b0, dvs_r}) : shifted[DW-1:0];
    quo_nxt  = {quo_r[QW-2:0], fits};
    cnt_nxt  = cnt_r - CW'(1);
    busy_nxt = (cnt_r != CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- tb/sv/blm_meter_checker.sv -----
`default_nettype none

module blm_meter_checker
  import blm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_t                   in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  wire logic                  cfg_pready,
  output int unsigned                fail_count,
  output int unsigned                frames_pending,
  output int unsigned                frames_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BANDS = BANDS_DEFAULT;

  // Mirror of the configuration registers, taken from the write transactions.
  logic [CFG_REG_W-1:0] hold_frames;
  logic [CFG_REG_W-1:0] decay_div;

  // Mirror of the per-band state.
  logic [LEVEL_W-1:0] bar_level [NUM_BANDS];
  logic [LEVEL_W-1:0] roof_level [NUM_BANDS];
  logic [AGE_W-1:0]   roof_age [NUM_BANDS];

  // Meter frames predicted but not yet seen on the result channel.
  out_t expected_frames [$];

  int unsigned mismatches;
  assign fail_count = mismatches;

  // Moves one band's bar and roof by one frame and returns the frame shown.
  function automatic out_t advance_band(in_t item);
    int   bar;
    int   roof;
    int   age;
    int   lvl;
    int   fall_to;
    int   div_eff;
    out_t frame;
    lvl  = item.level;
    bar  = bar_level[item.band];
    roof = roof_level[item.band];
    age  = roof_age[item.band];

    // The bar jumps a third of the way on a large rise, sinks by one on a fall.
    if (lvl > bar + int'(SMALL_RISE)) begin
      bar = (2 * bar + lvl) / 3;
    end else if (lvl < bar) begin
      bar = bar - 1;
    end else begin
      bar = lvl;
    end

    if (bar > roof) begin
      roof = bar;
      age  = 1;
    end

    frame.band_out    = item.band;
    frame.bar_height  = LEVEL_W'(bar);
    frame.roof_height = LEVEL_W'(roof);

    // Age the roof for the next frame; a zero divisor acts as one.
    if (age != 0) begin
      fall_to = roof;
      if (age > int'(hold_frames)) begin
        div_eff = (decay_div == '0) ? 1 : int'(decay_div);
        fall_to = fall_to - age / div_eff;
      end
      if (fall_to < 0) begin
        roof = 0;
        age  = 0;
      end else begin
        roof = fall_to;
        if (age < int'(AGE_MAX)) begin
          age = age + 1;
        end
      end
    end

    bar_level[item.band]  = LEVEL_W'(bar);
    roof_level[item.band] = LEVEL_W'(roof);
    roof_age[item.band]   = AGE_W'(age);
    return frame;
  endfunction

  // Watch all three ports at each rising edge.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      hold_frames = HOLD_RESET;
      decay_div   = DIV_RESET;
      for (int k = 0; k < NUM_BANDS; k++) begin
        bar_level[k]  = '0;
        roof_level[k] = '0;
        roof_age[k]   = '0;
      end
      expected_frames.delete();
      mismatches     = 0;
      frames_checked <= 0;
    end else begin
      // Register writes.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == {REG_HOLD_TIME, 2'b00}) begin
          hold_frames = cfg_pwdata[CFG_REG_W-1:0];
        end else if (cfg_paddr == {REG_DECAY_DIVISOR, 2'b00}) begin
          decay_div = cfg_pwdata[CFG_REG_W-1:0];
        end
      end

      // Result transactions are compared against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: band_out=%0d bar_height=%0d roof_height=%0d",
                 out_data.band_out, out_data.bar_height, out_data.roof_height);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.band_out !== want.band_out) begin
            $error("band_out mismatch: expected %0d, actual %0d",
                   want.band_out, out_data.band_out);
            mismatches++;
          end
          if (out_data.bar_height !== want.bar_height) begin
            $error("bar_height mismatch (band %0d): expected %0d, actual %0d",
                   want.band_out, want.bar_height, out_data.bar_height);
            mismatches++;
          end
          if (out_data.roof_height !== want.roof_height) begin
            $error("roof_height mismatch (band %0d): expected %0d, actual %0d",
                   want.band_out, want.roof_height, out_data.roof_height);
            mismatches++;
          end
          frames_checked <= frames_checked + 1;
        end
      end

      // Item transactions produce one predicted frame each.
      if (in_valid && !in_stall) begin
        expected_frames.push_back(advance_band(in_data));
      end
    end
    frames_pending <= expected_frames.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_band_level_meter_peak_hold.sv -----
`default_nettype none

module tb_band_level_meter_peak_hold;

  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SQUARE
  } stall_mode_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_t                   in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_t                  out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned fail_count;
  int unsigned frames_pending;
  int unsigned frames_checked;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned settings_used  = 1;

  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;

  band_level_meter_peak_hold dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  blm_meter_checker meter_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver switches between random stall patterns: none, light, heavy and a square wave.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= mode_left[2];
        end
      endcase
    end
  end

  // Offers one item transaction; the sender may idle between bursts.
  task automatic send(input int unsigned band, input int unsigned level);
    in_t         item;
    int unsigned gap;
    item.band  = BAND_W'(band);
    item.level = LEVEL_W'(level);
    gap        = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering items and waits until every frame has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Drains the meter, then writes hold time and decay divisor, with the bus idle between the two writes.
  task automatic set_meter(input int unsigned hold, input int unsigned div);
    drain();
    write_reg({REG_HOLD_TIME, 2'b00}, CFG_DATA_W'(hold));
    @(posedge clk);
    write_reg({REG_DECAY_DIVISOR, 2'b00}, CFG_DATA_W'(div));
    settings_used++;
  endtask

  // Mostly attack-and-release runs on one band, so roofs hold and decay;
  // the rest are single items with random band and level.
  task automatic run_random(input int unsigned count);
    int unsigned done;
    int unsigned run_band;
    int unsigned run_len;
    int unsigned peak;
    int unsigned attack;
    int unsigned lvl;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 3) == 0) begin
        send($urandom_range(0, 31), $urandom_range(0, 255));
        done++;
      end else begin
        run_band = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
        run_len  = $urandom_range(4, 40);
        peak     = $urandom_range(0, 255);
        attack   = $urandom_range(1, 6);
        for (int k = 0; k < run_len && done < count; k++) begin
          if (k < attack) begin
            lvl = peak;
          end else if ($urandom_range(0, 7) == 0) begin
            lvl = $urandom_range(0, 255);
          end else begin
            lvl = $urandom_range(0, peak / 8);
          end
          send(run_band, lvl);
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: large rise, rise within four, exact level, slow drop.
    send(0, 255);
    send(0, 255);
    send(0, 255);
    send(0, 180);
    send(0, 184);
    send(0, 0);
    send(31, 255);
    send(31, 0);
    send(31, 0);
    send(16, 5);
    send(16, 4);
    send(21, 8'hAA);
    send(10, 8'h55);
    run_random(84);

    // No hold and a divisor of one: roofs fall faster with every frame until they reach zero.
    set_meter(0, 1);
    send(0, 0);
    send(0, 0);
    send(0, 0);
    run_random(84);

    // Longest hold and largest divisor.
    set_meter(255, 255);
    run_random(84);

    // Zero divisor, which acts as a divisor of one.
    set_meter(0, 0);
    send(2, 255);
    send(2, 0);
    send(2, 0);
    run_random(84);

    set_meter(4, 255);
    run_random(84);

    set_meter($urandom_range(0, 40), $urandom_range(1, 8));
    run_random(84);

    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d items under %0d register settings; %0d meter frames checked.",
             items_sent, settings_used, frames_checked);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("** band_level_meter_peak_hold: PASSED **");
    end else begin
      $display("** band_level_meter_peak_hold: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timed out with %0d frames outstanding.", frames_pending);
    $display("** band_level_meter_peak_hold: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/blm_pkg.sv
hdl/blm_band_mem.sv
hdl/blm_div.sv
hdl/band_level_meter_peak_hold.sv
tb/sv/blm_meter_checker.sv
tb/sv/tb_band_level_meter_peak_hold.sv
